>>> rtl/core/mexp_pkg.sv
// shared constants, types and unit request/response structs for the modexp core
// no dependencies
package mexp_pkg;

    localparam int EXP_BITS_DEF = 31;
    localparam int BASE_W       = 31;
    localparam int EXP_W        = 31;
    localparam int RES_W        = 30;
    localparam int PROD_W       = 60;
    localparam int RED_W        = 32;

    localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
    localparam logic [30:0]      MU    = 31'((64'd1 << 60) / 64'd1000000007);

    typedef enum logic {
        DEST_ACC,
        DEST_BASE
    } t_dest;

    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] op_a;
        logic [RES_W-1:0]  op_b;
        t_dest             dest;
    } t_mm_req;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] value;
        t_dest            dest;
    } t_mm_rsp;

endpackage

>>> rtl/core/mexp_in_if.sv
// request channel: base and exponent with valid/ready
// depends on mexp_pkg
interface mexp_in_if import mexp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base_value;
    logic [EXP_W-1:0]  exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

>>> rtl/core/mexp_out_if.sv
// response channel: power result with valid/ready
// depends on mexp_pkg
interface mexp_out_if import mexp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

>>> rtl/core/mexp_modmul.sv
// four-stage pipelined modular multiplier, barrett reduction by the fixed prime
// depends on mexp_pkg
module mexp_modmul import mexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_dest             r_s1_dest, r_s2_dest, r_s3_dest, r_s4_dest;
    logic [PROD_W-1:0] r_s1_prod;
    logic [30:0]       r_s2_q3;
    logic [RED_W-1:0]  r_s2_xlo;
    logic [RED_W-1:0]  r_s3_rem;
    logic [RES_W-1:0]  r_s4_value;

    logic [60:0]       w_prod;
    logic [61:0]       w_q2;
    logic [60:0]       w_qp;
    logic [RED_W-1:0]  w_sub1;
    logic [RED_W-1:0]  w_sub2;
    logic [RED_W-1:0]  w_red;

    assign w_prod = 61'(i_req.op_a) * 61'(i_req.op_b);
    assign w_q2   = 62'(r_s1_prod[59:29]) * 62'(MU);
    assign w_qp   = 61'(r_s2_q3) * 61'(PRIME);
    assign w_sub1 = r_s3_rem - RED_W'(PRIME);
    assign w_sub2 = r_s3_rem - RED_W'({PRIME, 1'b0});

    always_comb begin
        if (r_s3_rem >= RED_W'({PRIME, 1'b0})) begin
            w_red = w_sub2;
        end else if (r_s3_rem >= RED_W'(PRIME)) begin
            w_red = w_sub1;
        end else begin
            w_red = r_s3_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dest  <= i_req.dest;
        r_s1_prod  <= w_prod[PROD_W-1:0];
        r_s2_dest  <= r_s1_dest;
        r_s2_q3    <= w_q2[61:31];
        r_s2_xlo   <= r_s1_prod[RED_W-1:0];
        r_s3_dest  <= r_s2_dest;
        r_s3_rem   <= r_s2_xlo - w_qp[RED_W-1:0];
        r_s4_dest  <= r_s3_dest;
        r_s4_value <= w_red[RES_W-1:0];
    end

    assign o_rsp.valid = r_s4_valid;
    assign o_rsp.value = r_s4_value;
    assign o_rsp.dest  = r_s4_dest;

endmodule

>>> rtl/core/modular_exponentiation_core.sv
// top level: base^exponent mod 1000000007, right-to-left square and multiply
// depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_modmul
//
//  port    dir  handshake    payload
//  i_in    in   valid/ready  base_value[30:0], exponent[30:0]
//  o_out   out  valid/ready  power_result[29:0]
//
// each exponent bit issues a multiply (only when the bit is set) and a square
// into the shared four-stage modular multiplier; the base is reduced by one pass
// through the same unit. i_in.ready is high only while the sequencer is idle.
// a finished result waits in the output register, and the next request may be
// taken meanwhile. i_rst_n is synchronous and clears the sequencer and output
// valid.
module modular_exponentiation_core import mexp_pkg::*; #(
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);

    localparam int CNT_W = $clog2(EXP_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_MUL,
        S_SQ,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [RES_W-1:0] r_acc, n_acc;
    logic [RES_W-1:0] r_base, n_base;
    logic [EXP_W-1:0] r_exp, n_exp;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_out_valid, n_out_valid;
    logic [RES_W-1:0] r_out_value, n_out_value;

    t_mm_req w_req;
    t_mm_rsp w_rsp;

    mexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.power_result = r_out_value;

    always_comb begin
        w_req = '0;
        w_req.dest = DEST_BASE;
        case (r_state)
            S_IDLE: begin
                w_req.valid = i_in.valid;
                w_req.op_a  = i_in.base_value;
                w_req.op_b  = RES_W'(1);
            end
            S_MUL: begin
                w_req.valid = r_exp[0];
                w_req.op_a  = {1'b0, r_acc};
                w_req.op_b  = r_base;
                w_req.dest  = DEST_ACC;
            end
            S_SQ: begin
                w_req.valid = 1'b1;
                w_req.op_a  = {1'b0, r_base};
                w_req.op_b  = r_base;
            end
            default: begin
                w_req.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        n_left      = r_left;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_value = r_out_value;

        if (w_rsp.valid && w_rsp.dest == DEST_ACC) begin
            n_acc = w_rsp.value;
        end
        if (w_rsp.valid && w_rsp.dest == DEST_BASE) begin
            n_base = w_rsp.value;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_acc   = RES_W'(1);
                    n_exp   = i_in.exponent;
                    n_left  = CNT_W'(EXP_BITS);
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_rsp.valid && w_rsp.dest == DEST_BASE) begin
                    n_state = (r_left == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_exp   = r_exp >> 1;
                n_left  = r_left - CNT_W'(1);
                n_state = S_WAIT;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_base      <= n_base;
            r_exp       <= n_exp;
            r_left      <= n_left;
            r_out_value <= n_out_value;
        end
    end

`ifndef SYNTHESIS
    a_rsp_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (w_rsp.value < PRIME))
        else $error("multiplier result not reduced");

    a_done_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_acc < PRIME))
        else $error("accumulator out of range at completion");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left <= CNT_W'(EXP_BITS)))
        else $error("round counter out of range");

    a_no_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT || r_state == S_DONE) |-> !w_req.valid)
        else $error("multiplier issued while waiting");
`endif

endmodule
